// File: hdl/bdsw_pkg.sv
// Shared types and constants of the binary dilation block.
package bdsw_pkg;

  // Widths of the configuration register fields.
  localparam int FW_W = 11;
  localparam int FH_W = 16;
  localparam int MS_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 16;

  // Register values after reset.
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd768;
  localparam logic [MS_W-1:0] MASK_SIZE_RST    = 4'd3;

  // A pixel above this level is foreground.
  localparam logic [7:0] FG_THRESHOLD = 8'd127;
  localparam logic [7:0] PIX_ON       = 8'd255;
  localparam logic [7:0] PIX_OFF      = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MASK_SIZE    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0] dilated;
    logic       row_end;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_t;

endpackage

// File: hdl/bdsw_stream_if.sv
// Valid/ready channel interface with a typed payload.
interface bdsw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/binary_dilation_square_window.sv
// Pixels pass through stage 1 and, once their window is complete, the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the column-count
// RAM, read at the pixel transfer and written as the pixel leaves stage 1, with a bypass for
// back-to-back hits. Reset clears the row and column position and all valid flags, sets the
// horizontal count to its maximum and loads the registers with width 1024, height 768 and
// mask 3. The column-count RAM is not cleared: the first row of each frame writes it unread.
module binary_dilation_square_window #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_MASK  = 15
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bdsw_stream_if.sink   pix_i,
  bdsw_stream_if.source res_o,
  bdsw_stream_if.sink   cfg_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWC = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EWC > bdsw_pkg::FW_W) ? EWC : bdsw_pkg::FW_W;
  localparam int GW  = $clog2(MAX_MASK + 1);
  localparam int MW  = (GW > bdsw_pkg::MS_W) ? GW : bdsw_pkg::MS_W;
  localparam int RW  = bdsw_pkg::FH_W;

  localparam logic [GW-1:0] GAP_MAX = GW'(MAX_MASK);

  function automatic logic [GW-1:0] sat_inc(input logic [GW-1:0] v);
    return (v >= GAP_MAX) ? GAP_MAX : v + GW'(1);
  endfunction

  // Configuration registers.
  logic [bdsw_pkg::FW_W-1:0] width_q;
  logic [bdsw_pkg::FH_W-1:0] height_q;
  logic [bdsw_pkg::MS_W-1:0] mask_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bdsw_pkg::FRAME_WIDTH_RST;
      height_q <= bdsw_pkg::FRAME_HEIGHT_RST;
      mask_q   <= bdsw_pkg::MASK_SIZE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        bdsw_pkg::CFG_FRAME_WIDTH: begin
          width_q <= cfg_i.data.value[bdsw_pkg::FW_W-1:0];
        end
        bdsw_pkg::CFG_FRAME_HEIGHT: begin
          height_q <= cfg_i.data.value[bdsw_pkg::FH_W-1:0];
        end
        bdsw_pkg::CFG_MASK_SIZE: begin
          mask_q <= cfg_i.data.value[bdsw_pkg::MS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective frame geometry and mask size.
  logic [EW-1:0] width_ext;
  logic [EW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [MW-1:0] mask_ext;
  logic [MW-1:0] m_eff;

  always_comb begin
    width_ext = EW'(width_q);
    if (width_q == '0) begin
      w_eff = EW'(1);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    h_eff = (height_q == '0) ? RW'(1) : height_q;
    mask_ext = MW'(mask_q);
    if (mask_q == '0) begin
      m_eff = MW'(1);
    end else if (mask_ext > MW'(MAX_MASK)) begin
      m_eff = MW'(MAX_MASK);
    end else begin
      m_eff = mask_ext;
    end
  end

  // Stage 1 and output register handshake.
  logic   s1_valid_q;
  logic   s1_emit_q;
  logic   out_valid_q;
  logic   out_free;
  logic   s1_fire;
  logic   in_accept;

  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && (!s1_emit_q || out_free);
  assign pix_i.ready = !s1_valid_q || s1_fire;
  assign in_accept   = pix_i.valid && pix_i.ready;

  // Position of the incoming pixel. A position left past the frame by a register
  // change wraps to the start of the next row or frame before use.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          pre_wrap;
  logic [CW-1:0] col_n;
  logic [RW:0]   row_t;
  logic [RW-1:0] row_n;
  logic [EW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          post_wrap;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          emit_n;
  logic          last_col_n;
  logic          last_row_n;

  always_comb begin
    pre_wrap = EW'(col_q) >= w_eff;
    col_n    = pre_wrap ? '0 : col_q;
    row_t    = (RW+1)'(row_q) + (RW+1)'(pre_wrap);
    row_n    = (row_t >= (RW+1)'(h_eff)) ? '0 : row_t[RW-1:0];

    col_inc    = EW'(col_n) + EW'(1);
    row_inc    = (RW+1)'(row_n) + (RW+1)'(1);
    post_wrap  = col_inc >= w_eff;
    last_col_n = col_inc == w_eff;
    last_row_n = row_inc == (RW+1)'(h_eff);
    col_next   = post_wrap ? '0 : col_inc[CW-1:0];
    if (!post_wrap) begin
      row_next = row_n;
    end else if (row_inc >= (RW+1)'(h_eff)) begin
      row_next = '0;
    end else begin
      row_next = row_inc[RW-1:0];
    end

    // The window is complete once row and column have both reached mask-1.
    emit_n = (row_inc >= (RW+1)'(m_eff)) && (col_inc >= EW'(m_eff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_next;
      row_q <= row_next;
    end
  end

  // Stage 1 payload.
  logic [CW-1:0] s1_col_q;
  logic          s1_fg_q;
  logic          s1_row0_q;
  logic          s1_col0_q;
  logic          s1_rend_q;
  logic          s1_fend_q;
  logic          fwd_q;
  logic [GW-1:0] fwd_gap_q;
  logic [GW-1:0] ram_rdata;
  logic [GW-1:0] gap_old;
  logic [GW-1:0] gap_new;
  logic          vhit;
  logic [GW-1:0] hgap_q;
  logic [GW-1:0] hgap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // The count for a column written by the item leaving stage 1 in the same
  // cycle is taken from the bypass, since the RAM still returns the old value.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q  <= col_n;
      s1_fg_q   <= pix_i.data.pixel > bdsw_pkg::FG_THRESHOLD;
      s1_row0_q <= row_n == '0;
      s1_col0_q <= col_n == '0;
      s1_emit_q <= emit_n;
      s1_rend_q <= last_col_n;
      s1_fend_q <= last_col_n && last_row_n;
      fwd_q     <= s1_fire && (s1_col_q == col_n);
      fwd_gap_q <= gap_new;
    end
  end

  bdsw_gap_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (GW)
  ) u_gap_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (gap_new),
    .re_i    (in_accept),
    .raddr_i (col_n),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    gap_old = fwd_q ? fwd_gap_q : ram_rdata;
    if (s1_fg_q) begin
      gap_new = '0;
    end else if (s1_row0_q) begin
      gap_new = GAP_MAX;
    end else begin
      gap_new = sat_inc(gap_old);
    end
    vhit = MW'(gap_new) < m_eff;
    if (vhit) begin
      hgap_d = '0;
    end else if (s1_col0_q) begin
      hgap_d = GAP_MAX;
    end else begin
      hgap_d = sat_inc(hgap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hgap_q <= GAP_MAX;
    end else if (s1_fire) begin
      hgap_q <= hgap_d;
    end
  end

  // Output register.
  bdsw_pkg::res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out_q.dilated   <= (MW'(hgap_d) < m_eff) ? bdsw_pkg::PIX_ON : bdsw_pkg::PIX_OFF;
      out_q.row_end   <= s1_rend_q;
      out_q.frame_end <= s1_fend_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // A transfer always lands in stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> s1_valid_q)
    else $error("accepted pixel did not reach stage 1");

  // A windowed item leaving stage 1 shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_emit_q |=> out_valid_q)
    else $error("result lost between stage 1 and output register");

  // The end of a frame is always the end of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.row_end)
    else $error("frame end without row end");

  // The horizontal count saturates and never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hgap_q <= GAP_MAX)
    else $error("horizontal count out of range");

endmodule

// File: hdl/bdsw_gap_ram.sv
// Simple dual-port RAM with a registered read port for the per-column counts.
module bdsw_gap_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 4,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the binary dilation block with a square window.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_MASK       = 15;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 320;

  logic clk_i;
  logic rst_ni;

  bdsw_stream_if #(.T(bdsw_pkg::pix_t)) pix_if ();
  bdsw_stream_if #(.T(bdsw_pkg::res_t)) res_if ();
  bdsw_stream_if #(.T(bdsw_pkg::cfg_t)) cfg_if ();

  binary_dilation_square_window dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the block: register copies, per-column vertical gaps, the
  // horizontal gap and the raster position of the next pixel.
  logic [bdsw_pkg::FW_W-1:0] frame_width_q;
  logic [bdsw_pkg::FH_W-1:0] frame_height_q;
  logic [bdsw_pkg::MS_W-1:0] mask_size_q;
  logic [3:0]      col_gap_mem [MAX_WIDTH];
  logic [3:0]      horiz_gap;
  int unsigned     row_pos;
  int unsigned     col_pos;

  bdsw_pkg::pix_t pixel_q[$];
  bdsw_pkg::res_t dilation_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int pixels_sent;
  int results_seen;
  int mismatches;
  int reg_writes;
  int quiet_cycles;

  logic [7:0] frame_thresh [9] = '{8'd0, 8'd127, 8'd0, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127};
  logic [7:0] frame_tiny   [3] = '{8'd128, 8'd255, 8'd127};
  logic [7:0] frame_mid    [6] = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  logic [7:0] frame_after  [4] = '{8'd0, 8'd0, 8'd128, 8'd0};

  function automatic int unsigned eff_width(input logic [15:0] raw);
    int unsigned w;
    w = raw[bdsw_pkg::FW_W-1:0];
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height(input logic [15:0] raw);
    return (raw[bdsw_pkg::FH_W-1:0] == 0) ? 1 : raw[bdsw_pkg::FH_W-1:0];
  endfunction

  function automatic int unsigned eff_mask(input logic [15:0] raw);
    int unsigned m;
    m = raw[bdsw_pkg::MS_W-1:0];
    if (m == 0) m = 1;
    if (m > MAX_MASK) m = MAX_MASK;
    return m;
  endfunction

  function automatic logic [3:0] gap_inc(input logic [3:0] v);
    return (v >= MAX_MASK) ? 4'(MAX_MASK) : v + 4'd1;
  endfunction

  function automatic void predict_dilation(input logic [7:0] pixel);
    int unsigned    w, h, m;
    logic           fg;
    logic           vhit;
    logic [3:0]     g;
    bdsw_pkg::res_t r;
    w  = eff_width(16'(frame_width_q));
    h  = eff_height(frame_height_q);
    m  = eff_mask(16'(mask_size_q));
    fg = pixel > bdsw_pkg::FG_THRESHOLD;
    // A register write may have left the position past the new frame size.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    if (fg) g = 4'd0;
    else if (row_pos == 0) g = 4'(MAX_MASK);
    else g = gap_inc(col_gap_mem[col_pos]);
    col_gap_mem[col_pos] = g;
    vhit = (g <= m - 1);
    if (vhit) horiz_gap = 4'd0;
    else if (col_pos == 0) horiz_gap = 4'(MAX_MASK);
    else horiz_gap = gap_inc(horiz_gap);
    if (row_pos >= m - 1 && col_pos >= m - 1) begin
      r.dilated   = (horiz_gap <= m - 1) ? bdsw_pkg::PIX_ON : bdsw_pkg::PIX_OFF;
      r.row_end   = (col_pos == w - 1);
      r.frame_end = r.row_end && (row_pos == h - 1);
      dilation_q.push_back(r);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // Pixels still needed to reach the start of a frame under the current setting.
  function automatic int unsigned pixels_to_frame_start();
    int unsigned w, h, r, c;
    w = eff_width(16'(frame_width_q));
    h = eff_height(frame_height_q);
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    if (r == 0 && c == 0) return 0;
    return (h - r) * w - c;
  endfunction

  function automatic logic [7:0] random_pixel(input int unsigned fg_pct);
    if ($urandom_range(99, 0) < fg_pct) return 8'($urandom_range(255, 128));
    return 8'($urandom_range(127, 0));
  endfunction

  // Pixel driver: valid is held until the transfer, and the predictor is
  // advanced on every accepted pixel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        predict_dilation(pix_if.data.pixel);
        void'(pixel_q.pop_front());
        pixels_sent++;
      end
      if (pix_if.valid && !pix_if.ready) begin
        // Hold the offered pixel.
      end else if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        pix_if.valid <= 1'b1;
        pix_if.data  <= pixel_q[0];
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin : result_monitor
    bdsw_pkg::res_t want;
    bdsw_pkg::res_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        results_seen++;
        if (dilation_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected result dilated=%0d row_end=%0b frame_end=%0b",
                     got.dilated, got.row_end, got.frame_end);
        end else begin
          want = dilation_q.pop_front();
          if (got.dilated !== want.dilated || got.row_end !== want.row_end ||
              got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tb: result %0d mismatch: expected dilated=%0d row_end=%0b ",
                        "frame_end=%0b, got dilated=%0d row_end=%0b frame_end=%0b"},
                       results_seen, want.dilated, want.row_end, want.frame_end,
                       got.dilated, got.row_end, got.frame_end);
          end
        end
      end
      res_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input bdsw_pkg::cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    reg_writes++;
    case (idx)
      bdsw_pkg::CFG_FRAME_WIDTH:  frame_width_q  = val[bdsw_pkg::FW_W-1:0];
      bdsw_pkg::CFG_FRAME_HEIGHT: frame_height_q = val[bdsw_pkg::FH_W-1:0];
      bdsw_pkg::CFG_MASK_SIZE:    mask_size_q    = val[bdsw_pkg::MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pixel_q.size() != 0 || dilation_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_random(input int unsigned count, input int unsigned fg_pct);
    bdsw_pkg::pix_t p;
    repeat (count) begin
      p.pixel = random_pixel(fg_pct);
      pixel_q.push_back(p);
    end
  endtask

  task automatic push_pixel(input logic [7:0] v);
    bdsw_pkg::pix_t p;
    p.pixel = v;
    pixel_q.push_back(p);
  endtask

  // A column whose count was never written must not be read, so a wider
  // frame is only set up once the current frame has been completed.
  task automatic set_frame(input logic [15:0] w_raw, input logic [15:0] h_raw,
                           input logic [15:0] m_raw);
    int unsigned pad;
    wait_drained();
    write_reg(bdsw_pkg::CFG_FRAME_HEIGHT, h_raw);
    write_reg(bdsw_pkg::CFG_MASK_SIZE, m_raw);
    if (eff_width(w_raw) > eff_width(16'(frame_width_q))) begin
      pad = pixels_to_frame_start();
      if (pad != 0) begin
        push_random(pad, 20);
        wait_drained();
      end
    end
    write_reg(bdsw_pkg::CFG_FRAME_WIDTH, w_raw);
  endtask

  task automatic select_idling(input int phase_no);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  initial begin : stimulus
    int unsigned w, h, m, lim, n, fg_pct;
    logic [15:0] w_raw, h_raw, m_raw;
    int          phase_no;
    int          random_pixels;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    pix_if.valid   = 1'b0;
    pix_if.data    = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pixels_sent    = 0;
    results_seen   = 0;
    mismatches     = 0;
    reg_writes     = 0;
    frame_width_q  = bdsw_pkg::FRAME_WIDTH_RST;
    frame_height_q = bdsw_pkg::FRAME_HEIGHT_RST;
    mask_size_q    = bdsw_pkg::MASK_SIZE_RST;
    horiz_gap      = 4'(MAX_MASK);
    row_pos        = 0;
    col_pos        = 0;
    foreach (col_gap_mem[i]) col_gap_mem[i] = 4'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: threshold edge at 127 against 128, the smallest frame from
    // zero-valued registers, a window larger than the frame, and a register
    // write in the middle of a frame.
    set_frame(16'd3, 16'd3, 16'd3);
    foreach (frame_thresh[i]) push_pixel(frame_thresh[i]);
    set_frame(16'd0, 16'd0, 16'd0);
    foreach (frame_tiny[i]) push_pixel(frame_tiny[i]);
    select_idling(3);
    set_frame(16'd2, 16'd2, 16'd4);
    repeat (4) push_pixel(8'd255);
    set_frame(16'd4, 16'd3, 16'd2);
    foreach (frame_mid[i]) push_pixel(frame_mid[i]);
    set_frame(16'd3, 16'd3, 16'd2);
    foreach (frame_after[i]) push_pixel(frame_after[i]);

    // Tallest frame with the largest window, then the widest single row.
    select_idling(1);
    set_frame(16'd1, 16'hFFFF, 16'hFFFF);
    push_random(40, 30);
    select_idling(2);
    set_frame(16'hFFFF, 16'd1, 16'd1);
    push_random(MAX_WIDTH, 10);

    phase_no      = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_TARGET) begin
      w   = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h   = (w > 12) ? $urandom_range(4, 1) : $urandom_range(12, 1);
      lim = (w < h) ? w : h;
      if (lim > MAX_MASK) lim = MAX_MASK;
      m   = ($urandom_range(4, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(lim, 1);
      w_raw = ($urandom_range(15, 0) == 0) ? 16'd0 : 16'(w);
      h_raw = ($urandom_range(15, 0) == 0) ? 16'd0 : 16'(h);
      m_raw = 16'(m);
      select_idling(phase_no);
      set_frame(w_raw, h_raw, m_raw);
      n = eff_width(w_raw) * eff_height(h_raw);
      // Mostly whole frames; now and then a partial one that the next setting interrupts.
      if ($urandom_range(9, 0) < 7) n = n * $urandom_range(2, 1);
      else n = $urandom_range(n, 1);
      case ($urandom_range(3, 0))
        0: fg_pct = 3;
        1: fg_pct = 10;
        2: fg_pct = 30;
        default: fg_pct = 60;
      endcase
      push_random(n, fg_pct);
      random_pixels += n;
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("tb: %0d pixels in, %0d results checked, %0d register writes, %0d mismatches",
             pixels_sent, results_seen, reg_writes, mismatches);
    $display("tb: frames from 1x1 up to 1024 wide and 65535 tall, windows of 1 to 15");
    if (mismatches == 0 && dilation_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: binary_dilation_square_window.f
hdl/bdsw_pkg.sv
hdl/bdsw_stream_if.sv
hdl/bdsw_gap_ram.sv
hdl/binary_dilation_square_window.sv
dv/tb_top.sv
